// ===== design/tllbc_pkg.sv =====
// Shared types and constants of the two-list LRU block cache directory.
// Used by tllbc_ctrl, tllbc_dp and two_list_lru_block_cache; no dependencies.
`timescale 1ns / 1ps
package tllbc_pkg;

  localparam int ENTRIES_DEF  = 32;
  localparam int TAG_BITS_DEF = 32;
  localparam int REF_BITS_DEF = 8;

  // Item kinds
  localparam logic [1:0] KIND_GET     = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_FREE    = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_HIT_ACT   = 3'd0;
  localparam logic [2:0] ST_HIT_INACT = 3'd1;
  localparam logic [2:0] ST_MISS      = 3'd2;
  localparam logic [2:0] ST_NO_FREE   = 3'd3;
  localparam logic [2:0] ST_BAD_REL   = 3'd4;
  localparam logic [2:0] ST_OK        = 3'd5;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STEP,
    CMD_SWITCH,
    CMD_HIT,
    CMD_FULL,
    CMD_MISS,
    CMD_REL,
    CMD_UNLINK,
    CMD_INS_ACT_HEAD,
    CMD_INS_ACT_TAIL,
    CMD_INS_INACT_HEAD,
    CMD_FREE_START,
    CMD_FREE_STEP
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       walk_ok;
    logic       match;
    logic       phase;
    logic       tail_free;
    logic       rel_bad;
    logic       rel_last;
    logic       free_go;
  } dp_status_t;

endpackage

// ===== design/two_list_lru_block_cache.sv =====
// Two-list LRU block cache directory, one item at a time, one result word each.
// A get walks the active list, then the inactive list, one node per step; a release
// relinks only when the last reference goes; free pages walks up to ENTRIES slots.
// A new item is taken only after the previous result word has been accepted.
// Reset (rst, synchronous): all slots empty on the inactive ring, no clearing pass.
`timescale 1ns / 1ps
module two_list_lru_block_cache #(
  parameter int ENTRIES  = tllbc_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = tllbc_pkg::TAG_BITS_DEF,
  parameter int REF_BITS = tllbc_pkg::REF_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // blk_no[31:0], slot[36:32], free_limit[42:37], zero fill
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // slot_out[4:0], status[7:5], disk_rd[8],
                                 // need_page[9], freed_count[15:10]
);

  tllbc_pkg::dp_cmd_t    cmd;
  tllbc_pkg::dp_status_t st;

  logic [4:0] slot_out;
  logic [2:0] status;
  logic       disk_rd;
  logic       need_page;
  logic [5:0] freed_count;

  tllbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tllbc_dp #(
    .ENTRIES  (ENTRIES),
    .TAG_BITS (TAG_BITS),
    .REF_BITS (REF_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_kind       (s_tuser),
    .in_blk_no     (s_tdata[31:0]),
    .in_slot       (s_tdata[36:32]),
    .in_free_limit (s_tdata[42:37]),
    .st            (st),
    .slot_out      (slot_out),
    .status        (status),
    .disk_rd       (disk_rd),
    .need_page     (need_page),
    .freed_count   (freed_count)
  );

  // Pack the result word
  assign m_tdata = {freed_count, need_page, disk_rd, status, slot_out};

endmodule

// ===== design/tllbc_dp.sv =====
// Datapath: slot directory, link rings, walk cursor and result word registers.
// Depends on tllbc_pkg; driven by commands from tllbc_ctrl.
`timescale 1ns / 1ps
module tllbc_dp #(
  parameter int ENTRIES  = tllbc_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = tllbc_pkg::TAG_BITS_DEF,
  parameter int REF_BITS = tllbc_pkg::REF_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tllbc_pkg::dp_cmd_t    cmd,
  input  logic [1:0]            in_kind,
  input  logic [31:0]           in_blk_no,
  input  logic [4:0]            in_slot,
  input  logic [5:0]            in_free_limit,
  output tllbc_pkg::dp_status_t st,
  output logic [4:0]            slot_out,
  output logic [2:0]            status,
  output logic                  disk_rd,
  output logic                  need_page,
  output logic [5:0]            freed_count
);

  localparam int NODES = ENTRIES + 2;
  localparam int NW    = $clog2(NODES);
  localparam int SW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam logic [NW-1:0] ACT_HEAD   = NW'(ENTRIES);
  localparam logic [NW-1:0] INACT_HEAD = NW'(ENTRIES + 1);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  logic [TAG_BITS-1:0] tag_store [ENTRIES];
  logic                valid_mark [ENTRIES];
  logic [REF_BITS-1:0] ref_count [ENTRIES];
  logic                page_held [ENTRIES];
  logic [NW-1:0]       next_link [ENTRIES];
  logic [NW-1:0]       prev_link [ENTRIES];

  // Ring head nodes live in registers beside the slot links
  logic [NW-1:0]       act_nx;
  logic [NW-1:0]       act_pv;
  logic [NW-1:0]       inact_nx;
  logic [NW-1:0]       inact_pv;

  logic [1:0]          kind;
  logic [TAG_BITS-1:0] tag;
  logic [4:0]          slot;
  logic [5:0]          limit;
  logic [NW-1:0]       cur;
  logic [NW-1:0]       tgt;
  logic [CW-1:0]       steps;
  logic                phase;

  logic [SW-1:0] cur_idx;
  logic [SW-1:0] slot_idx;
  logic [SW-1:0] tail_idx;
  logic [SW-1:0] tgt_idx;
  logic [NW-1:0] tail;
  logic [NW-1:0] tgt_nx;
  logic [NW-1:0] tgt_pv;
  logic          cur_is_slot;
  logic          slot_in_range;

  assign cur_idx       = cur[SW-1:0];
  assign slot_idx      = SW'(slot);
  assign tail          = inact_pv;
  assign tail_idx      = tail[SW-1:0];
  assign tgt_idx       = tgt[SW-1:0];
  assign tgt_nx        = next_link[tgt_idx];
  assign tgt_pv        = prev_link[tgt_idx];
  assign cur_is_slot   = cur < ACT_HEAD;
  assign slot_in_range = 32'(slot) < ENTRIES;

  // Status toward the controller
  always_comb begin
    st.kind      = kind;
    st.phase     = phase;
    st.walk_ok   = cur_is_slot && (steps < CW'(ENTRIES));
    st.match     = cur_is_slot && valid_mark[cur_idx] && (tag_store[cur_idx] == tag);
    st.tail_free = tail < ACT_HEAD;
    st.rel_bad   = !slot_in_range || (ref_count[slot_idx] == '0);
    st.rel_last  = ref_count[slot_idx] == REF_BITS'(1);
    st.free_go   = st.walk_ok && (freed_count < limit);
  end

  // Tag store has no reset; written only on a miss fill
  always_ff @(posedge clk) begin
    if (cmd == tllbc_pkg::CMD_MISS) begin
      tag_store[tail_idx] <= tag;
    end
  end

  // Directory, rings, cursor and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_mark[i] <= 1'b0;
        ref_count[i]  <= '0;
        page_held[i]  <= 1'b0;
        next_link[i]  <= (i == 0) ? INACT_HEAD : NW'(i - 1);
        prev_link[i]  <= (i == ENTRIES - 1) ? INACT_HEAD : NW'(i + 1);
      end
      act_nx      <= ACT_HEAD;
      act_pv      <= ACT_HEAD;
      inact_nx    <= NW'(ENTRIES - 1);
      inact_pv    <= '0;
      cur         <= '0;
      tgt         <= '0;
      steps       <= '0;
      phase       <= 1'b0;
      kind        <= '0;
      slot        <= '0;
      limit       <= '0;
      tag         <= '0;
      slot_out    <= '0;
      status      <= tllbc_pkg::ST_OK;
      disk_rd     <= 1'b0;
      need_page   <= 1'b0;
      freed_count <= '0;
    end else begin
      unique case (cmd)
        tllbc_pkg::CMD_LOAD: begin
          kind        <= in_kind;
          tag         <= TAG_BITS'(in_blk_no);
          slot        <= in_slot;
          limit       <= in_free_limit;
          cur         <= act_nx;
          steps       <= '0;
          phase       <= 1'b0;
          slot_out    <= '0;
          status      <= tllbc_pkg::ST_OK;
          disk_rd     <= 1'b0;
          need_page   <= 1'b0;
          freed_count <= '0;
        end
        tllbc_pkg::CMD_STEP: begin
          cur   <= next_link[cur_idx];
          steps <= steps + CW'(1);
        end
        tllbc_pkg::CMD_SWITCH: begin
          cur   <= inact_nx;
          steps <= '0;
          phase <= 1'b1;
        end
        tllbc_pkg::CMD_HIT: begin
          tgt      <= cur;
          slot_out <= 5'(cur);
          status   <= phase ? tllbc_pkg::ST_HIT_INACT : tllbc_pkg::ST_HIT_ACT;
          if (ref_count[cur_idx] != REF_MAX) begin
            ref_count[cur_idx] <= ref_count[cur_idx] + REF_BITS'(1);
          end
          if (!page_held[cur_idx]) begin
            need_page          <= 1'b1;
            disk_rd            <= 1'b1;
            page_held[cur_idx] <= 1'b1;
          end
        end
        tllbc_pkg::CMD_FULL: begin
          status <= tllbc_pkg::ST_NO_FREE;
        end
        tllbc_pkg::CMD_MISS: begin
          tgt                  <= tail;
          slot_out             <= 5'(tail);
          status               <= tllbc_pkg::ST_MISS;
          valid_mark[tail_idx] <= 1'b1;
          ref_count[tail_idx]  <= REF_BITS'(1);
          need_page            <= !page_held[tail_idx];
          page_held[tail_idx]  <= 1'b1;
          disk_rd              <= 1'b1;
        end
        tllbc_pkg::CMD_REL: begin
          if (st.rel_bad) begin
            status <= tllbc_pkg::ST_BAD_REL;
          end else begin
            ref_count[slot_idx] <= ref_count[slot_idx] - REF_BITS'(1);
            tgt                 <= NW'(slot);
          end
        end
        tllbc_pkg::CMD_UNLINK: begin
          // Bridge the neighbors, either of which may be a head node
          if (tgt_nx == ACT_HEAD) begin
            act_pv <= tgt_pv;
          end else if (tgt_nx == INACT_HEAD) begin
            inact_pv <= tgt_pv;
          end else begin
            prev_link[tgt_nx[SW-1:0]] <= tgt_pv;
          end
          if (tgt_pv == ACT_HEAD) begin
            act_nx <= tgt_nx;
          end else if (tgt_pv == INACT_HEAD) begin
            inact_nx <= tgt_nx;
          end else begin
            next_link[tgt_pv[SW-1:0]] <= tgt_nx;
          end
        end
        tllbc_pkg::CMD_INS_ACT_HEAD: begin
          next_link[tgt_idx] <= act_nx;
          if (act_nx == ACT_HEAD) begin
            act_pv <= tgt;
          end else begin
            prev_link[act_nx[SW-1:0]] <= tgt;
          end
          prev_link[tgt_idx] <= ACT_HEAD;
          act_nx             <= tgt;
        end
        tllbc_pkg::CMD_INS_ACT_TAIL: begin
          prev_link[tgt_idx] <= act_pv;
          if (act_pv == ACT_HEAD) begin
            act_nx <= tgt;
          end else begin
            next_link[act_pv[SW-1:0]] <= tgt;
          end
          next_link[tgt_idx] <= ACT_HEAD;
          act_pv             <= tgt;
        end
        tllbc_pkg::CMD_INS_INACT_HEAD: begin
          next_link[tgt_idx] <= inact_nx;
          if (inact_nx == INACT_HEAD) begin
            inact_pv <= tgt;
          end else begin
            prev_link[inact_nx[SW-1:0]] <= tgt;
          end
          prev_link[tgt_idx] <= INACT_HEAD;
          inact_nx           <= tgt;
        end
        tllbc_pkg::CMD_FREE_START: begin
          cur   <= inact_pv;
          steps <= '0;
        end
        tllbc_pkg::CMD_FREE_STEP: begin
          if (page_held[cur_idx]) begin
            page_held[cur_idx]  <= 1'b0;
            valid_mark[cur_idx] <= 1'b0;
            freed_count         <= freed_count + 6'd1;
          end
          cur   <= prev_link[cur_idx];
          steps <= steps + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A walk never runs past the slot count
  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    steps <= CW'(ENTRIES))
    else $error("walk step count exceeds slot count");

  // Free pass never drops more pages than asked
  a_freed_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd == tllbc_pkg::CMD_FREE_STEP) |-> (freed_count < limit))
    else $error("free pass past its limit");

  // A miss fill only happens on an inactive tail slot
  a_miss_tail: assert property (@(posedge clk) disable iff (rst)
    (cmd == tllbc_pkg::CMD_MISS) |-> (tail < ACT_HEAD))
    else $error("miss fill without free slot");
`endif

endmodule

// ===== design/tllbc_ctrl.sv =====
// Controller state machine: sequences search, relink and free walks.
// Depends on tllbc_pkg; issues commands to tllbc_dp and owns the handshakes.
`timescale 1ns / 1ps
module tllbc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  tllbc_pkg::dp_status_t st,
  output tllbc_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_UNL_AH,
    S_INS_AH,
    S_UNL_AT,
    S_INS_AT,
    S_REL,
    S_UNL_IH,
    S_INS_IH,
    S_FREE,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  // Command and next state
  always_comb begin
    cmd        = tllbc_pkg::CMD_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd        = tllbc_pkg::CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority case (st.kind)
          tllbc_pkg::KIND_GET:     state_next = S_SEARCH;
          tllbc_pkg::KIND_RELEASE: state_next = S_REL;
          tllbc_pkg::KIND_FREE: begin
            cmd        = tllbc_pkg::CMD_FREE_START;
            state_next = S_FREE;
          end
          default:                 state_next = S_OUT;
        endcase
      end
      S_SEARCH: begin
        priority if (st.walk_ok && st.match) begin
          cmd        = tllbc_pkg::CMD_HIT;
          state_next = S_UNL_AH;
        end else if (st.walk_ok) begin
          cmd = tllbc_pkg::CMD_STEP;
        end else if (!st.phase) begin
          cmd = tllbc_pkg::CMD_SWITCH;
        end else if (st.tail_free) begin
          cmd        = tllbc_pkg::CMD_MISS;
          state_next = S_UNL_AT;
        end else begin
          cmd        = tllbc_pkg::CMD_FULL;
          state_next = S_OUT;
        end
      end
      S_UNL_AH: begin
        cmd        = tllbc_pkg::CMD_UNLINK;
        state_next = S_INS_AH;
      end
      S_INS_AH: begin
        cmd        = tllbc_pkg::CMD_INS_ACT_HEAD;
        state_next = S_OUT;
      end
      S_UNL_AT: begin
        cmd        = tllbc_pkg::CMD_UNLINK;
        state_next = S_INS_AT;
      end
      S_INS_AT: begin
        cmd        = tllbc_pkg::CMD_INS_ACT_TAIL;
        state_next = S_OUT;
      end
      S_REL: begin
        cmd        = tllbc_pkg::CMD_REL;
        state_next = (!st.rel_bad && st.rel_last) ? S_UNL_IH : S_OUT;
      end
      S_UNL_IH: begin
        cmd        = tllbc_pkg::CMD_UNLINK;
        state_next = S_INS_IH;
      end
      S_INS_IH: begin
        cmd        = tllbc_pkg::CMD_INS_INACT_HEAD;
        state_next = S_OUT;
      end
      S_FREE: begin
        if (st.free_go) begin
          cmd = tllbc_pkg::CMD_FREE_STEP;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= (state_next == S_OUT);
    end
  end

`ifndef SYNTHESIS
  // Never take a new word while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input taken while result pending");

  // A taken result returns the block to idle
  a_out_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> (state == S_IDLE))
    else $error("result taken but not idle");

  // Output valid rises only from a busy state
  a_valid_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without work");
`endif

endmodule
